// ----- hdl/stack_bytecode_executor_defines.svh -----
// Assertion helpers used by the executor top level.
`ifndef STACK_BYTECODE_EXECUTOR_DEFINES_SVH
`define STACK_BYTECODE_EXECUTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet while in reset.
`define SBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while in reset.
`define SBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sbe_pkg.sv -----
`timescale 1ns / 1ps
package sbe_pkg;

  localparam int STACK_DEPTH  = 256;
  localparam int LOCAL_COUNT  = 16;
  localparam int RETURN_DEPTH = 64;
  localparam int IO_COUNT     = 8;

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int RP_W = $clog2(RETURN_DEPTH + 1);
  localparam int RA_W = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
  localparam int LI_W = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;

  localparam logic [63:0] Q_ONE   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] Q_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN   = 64'h8000_0000_0000_0000;
  localparam logic [15:0] PLEN_RESET = 16'h8000;

  typedef enum logic [4:0] {
    OP_PUSH  = 5'd0,  OP_ADD  = 5'd1,  OP_SUB  = 5'd2,  OP_MUL  = 5'd3,
    OP_DIV   = 5'd4,  OP_NEG  = 5'd5,  OP_LOAD = 5'd6,  OP_STORE = 5'd7,
    OP_JMP   = 5'd8,  OP_JZ   = 5'd9,  OP_JNZ  = 5'd10, OP_LT   = 5'd11,
    OP_GT    = 5'd12, OP_EQ   = 5'd13, OP_DUP  = 5'd14, OP_POP  = 5'd15,
    OP_SWAP  = 5'd16, OP_CALL = 5'd17, OP_RET  = 5'd18, OP_VGET = 5'd19,
    OP_VSET  = 5'd20, OP_SENSE = 5'd21, OP_ACT = 5'd22, OP_HALT = 5'd23
  } opc_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_HALTED = 2'd1,
    ST_ERROR  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_NEG, ALU_LT, ALU_GT, ALU_EQ
  } alu_op_e;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_EXEC, SQ_ALU, SQ_SWAP, SQ_DONE
  } seq_e;

  typedef struct packed {
    logic        start;
    alu_op_e     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } alu_rsp_t;

  // Magnitude of a signed value; the most negative value gives 2^63.
  function automatic logic [63:0] q_mag(input logic [63:0] x);
    q_mag = x[63] ? (64'd0 - x) : x;
  endfunction

  // Apply a sign to a magnitude, saturating to the signed range.
  function automatic logic [63:0] q_sat(input logic [63:0] m, input logic neg,
                                        input logic ovf);
    if (neg) begin
      q_sat = (ovf || m[63]) ? Q_MIN : (64'd0 - m);
    end else begin
      q_sat = (ovf || m[63]) ? Q_MAX : m;
    end
  endfunction

endpackage

// ----- hdl/sbe_ram.sv -----
`timescale 1ns / 1ps
module sbe_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/sbe_alu.sv -----
`timescale 1ns / 1ps
module sbe_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbe_pkg::alu_req_t req_i,
  output sbe_pkg::alu_rsp_t rsp_o
);
  import sbe_pkg::*;

  localparam int MUL_STEPS = 4;
  localparam int DIV_STEPS = 96;

  logic          busy_q;
  alu_op_e       op_q;
  logic [63:0]   a_q, b_q, ua_q, ub_q;
  logic          neg_q;
  logic [6:0]    cnt_q;
  logic [127:0]  acc_q;
  logic [95:0]   num_q;
  logic [63:0]   rem_q, quo_q;
  logic          ovf_q;

  logic [31:0]   pa, pb;
  logic [63:0]   pp;
  logic [127:0]  pp_sh;
  logic [64:0]   rem_ext;
  logic          ge;
  logic [64:0]   rem_sub;
  logic [63:0]   sum, dif;
  logic          done;
  logic [63:0]   res;

  // Pick one 32x32 partial product per step
  always_comb begin
    pa = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
    pb = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
    pp = 64'(pa) * 64'(pb);
    case (cnt_q[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // One restoring division step
  assign rem_ext = {rem_q, num_q[95]};
  assign ge      = rem_ext >= {1'b0, ub_q};
  assign rem_sub = rem_ext - {1'b0, ub_q};

  assign sum = a_q + b_q;
  assign dif = a_q - b_q;

  always_comb begin
    case (op_q)
      ALU_MUL: done = busy_q && (cnt_q == 7'(MUL_STEPS));
      ALU_DIV: done = busy_q && (cnt_q == 7'(DIV_STEPS));
      default: done = busy_q;
    endcase
  end

  // Final result from the held operands and accumulators
  always_comb begin
    case (op_q)
      ALU_ADD: res = (a_q[63] == b_q[63] && sum[63] != a_q[63])
                     ? (a_q[63] ? Q_MIN : Q_MAX) : sum;
      ALU_SUB: res = (a_q[63] != b_q[63] && dif[63] != a_q[63])
                     ? (a_q[63] ? Q_MIN : Q_MAX) : dif;
      ALU_MUL: res = q_sat(acc_q[95:32], neg_q, acc_q[127:96] != 32'd0);
      ALU_DIV: res = q_sat(quo_q, neg_q, ovf_q);
      ALU_NEG: res = (a_q == Q_MIN) ? Q_MAX : (64'd0 - a_q);
      ALU_LT:  res = ($signed(a_q) < $signed(b_q)) ? Q_ONE : 64'd0;
      ALU_GT:  res = ($signed(a_q) > $signed(b_q)) ? Q_ONE : 64'd0;
      ALU_EQ:  res = (a_q == b_q) ? Q_ONE : 64'd0;
      default: res = 64'd0;
    endcase
  end

  assign rsp_o.done = done;
  assign rsp_o.res  = res;

  // Control: raise busy and clear the step count on start, drop busy when done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 7'd1;
    end
  end

  // Datapath: latch operands on start, then a multiply accumulate or divide step per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      ua_q  <= q_mag(req_i.a);
      ub_q  <= q_mag(req_i.b);
      neg_q <= req_i.a[63] ^ req_i.b[63];
      acc_q <= '0;
      num_q <= {q_mag(req_i.a), 32'd0};
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q && !done) begin
      if (op_q == ALU_MUL) begin
        acc_q <= acc_q + pp_sh;
      end else if (op_q == ALU_DIV) begin
        ovf_q <= ovf_q | quo_q[63];
        quo_q <= {quo_q[62:0], ge};
        rem_q <= ge ? rem_sub[63:0] : rem_ext[63:0];
        num_q <= {num_q[94:0], 1'b0};
      end
    end
  end

endmodule

// ----- hdl/stack_bytecode_executor.sv -----
`timescale 1ns / 1ps
// Sequencing: an item is accepted in idle and executed; add, sub, mul, div, neg and
// compares then wait on the shared ALU, and the result loads the output register.
// A new item is taken only once the previous one is through; it is taken while
// the previous result waits in the output register.
// Reset: asynchronous, active low; clears pointers, pc, locals, vibe, ticks,
// halt flag and sets program_length to 32768. Stack memories are not cleared.
module stack_bytecode_executor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [4:0]          opcode_i,
  input  logic signed [15:0]  operand_i,
  input  logic signed [63:0]  immediate_i,
  input  logic signed [63:0]  sensor_reading_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic signed [15:0]  next_pc_o,
  output logic signed [63:0]  top_value_o,
  output logic [8:0]          stack_depth_o,
  output logic [6:0]          call_depth_o,
  output logic                actuator_write_o,
  output logic [2:0]          actuator_index_o,
  output logic signed [63:0]  actuator_value_o,
  output logic [31:0]         tick_count_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);
  import sbe_pkg::*;
  `include "stack_bytecode_executor_defines.svh"

  seq_e            state_q, state_d;
  opc_e            op_q;
  logic [15:0]     opd_q, imm_dummy;
  logic [63:0]     imm_q, sens_q;
  logic [SP_W-1:0] sp_q, sp_d;
  logic [RP_W-1:0] rp_q, rp_d;
  logic [63:0]     tos_q, tos_d, nos_q, nos_d;
  logic [15:0]     pc_q, pc_d, plen_q;
  logic [63:0]     vibe_q, vibe_d;
  logic [31:0]     ticks_q, ticks_d;
  logic            halted_q, halted_d;
  logic [63:0]     locals_q [LOCAL_COUNT];
  logic [63:0]     locals_d [LOCAL_COUNT];
  status_e         res_q, res_d;
  logic            actw_q, actw_d;
  logic [2:0]      acti_q, acti_d;
  logic [63:0]     actv_q, actv_d;
  logic            out_valid_q, out_load;

  logic            ds_we;
  logic [SA_W-1:0] ds_waddr, ds_raddr;
  logic [63:0]     ds_wdata, ds_rdata;
  logic            rs_we;
  logic [RA_W-1:0] rs_waddr, rs_raddr;
  logic [15:0]     rs_rdata;

  alu_req_t        alu_req;
  alu_rsp_t        alu_rsp;

  logic            accept;
  logic [15:0]     nxt;
  logic            loc_ok, io_ok, empty, full;
  logic [63:0]     pv;

  assign imm_dummy   = '0;
  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == SQ_IDLE);
  assign cfg_ready_o = 1'b1;

  // Reads always look at the entry under the top and the last return address
  assign ds_raddr = SA_W'(sp_q - SP_W'(2));
  assign rs_raddr = RA_W'(rp_q - RP_W'(1));
  assign rs_waddr = rp_q[RA_W-1:0];

  sbe_ram #(.DEPTH(STACK_DEPTH), .WIDTH(64)) u_dstack (
    .clk_i   (clk_i),
    .we_i    (ds_we),
    .waddr_i (ds_waddr),
    .wdata_i (ds_wdata),
    .raddr_i (ds_raddr),
    .rdata_o (ds_rdata)
  );

  sbe_ram #(.DEPTH(RETURN_DEPTH), .WIDTH(16)) u_rstack (
    .clk_i   (clk_i),
    .we_i    (rs_we),
    .waddr_i (rs_waddr),
    .wdata_i (nxt),
    .raddr_i (rs_raddr),
    .rdata_o (rs_rdata)
  );

  sbe_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  function automatic alu_op_e to_alu(input opc_e op);
    case (op)
      OP_ADD:  to_alu = ALU_ADD;
      OP_SUB:  to_alu = ALU_SUB;
      OP_MUL:  to_alu = ALU_MUL;
      OP_DIV:  to_alu = ALU_DIV;
      OP_NEG:  to_alu = ALU_NEG;
      OP_LT:   to_alu = ALU_LT;
      OP_GT:   to_alu = ALU_GT;
      default: to_alu = ALU_EQ;
    endcase
  endfunction

  assign nxt    = pc_q + 16'd1;
  assign loc_ok = !opd_q[15] && (opd_q < 16'(LOCAL_COUNT));
  assign io_ok  = !opd_q[15] && (opd_q < 16'(IO_COUNT));
  assign empty  = (sp_q == '0);
  assign full   = (sp_q == SP_W'(STACK_DEPTH));

  // Value a push-class instruction puts on the stack
  always_comb begin
    case (op_q)
      OP_PUSH:  pv = imm_q;
      OP_LOAD:  pv = locals_q[opd_q[LI_W-1:0]];
      OP_VGET:  pv = vibe_q;
      OP_SENSE: pv = sens_q;
      default:  pv = tos_q;
    endcase
  end

  // Sequencer: next state and state updates
  always_comb begin
    state_d  = state_q;
    sp_d     = sp_q;
    rp_d     = rp_q;
    tos_d    = tos_q;
    nos_d    = nos_q;
    pc_d     = pc_q;
    vibe_d   = vibe_q;
    ticks_d  = ticks_q;
    halted_d = halted_q;
    locals_d = locals_q;
    res_d    = res_q;
    actw_d   = actw_q;
    acti_d   = acti_q;
    actv_d   = actv_q;
    ds_we    = 1'b0;
    ds_waddr = sp_q[SA_W-1:0];
    ds_wdata = pv;
    rs_we    = 1'b0;
    alu_req  = '{start: 1'b0, op: to_alu(op_q), a: nos_q, b: tos_q};
    out_load = 1'b0;
    case (state_q)
      SQ_IDLE: begin
        if (accept) begin
          actw_d  = 1'b0;
          acti_d  = '0;
          actv_d  = '0;
          state_d = SQ_DONE;
          if (halted_q) begin
            res_d = ST_HALTED;
          end else if (pc_q[15] || pc_q >= plen_q) begin
            res_d = ST_ERROR;
          end else begin
            ticks_d = ticks_q + 32'd1;
            state_d = SQ_EXEC;
          end
        end
      end
      SQ_EXEC: begin
        res_d   = ST_ERROR;
        state_d = SQ_DONE;
        case (op_q)
          OP_PUSH, OP_LOAD, OP_VGET, OP_SENSE, OP_DUP: begin
            if (((op_q == OP_LOAD) && !loc_ok) || ((op_q == OP_SENSE) && !io_ok) ||
                ((op_q == OP_DUP) && empty)) begin
              res_d = ST_ERROR;
            end else if (!full) begin
              ds_we = 1'b1;
              tos_d = pv;
              sp_d  = sp_q + SP_W'(1);
              pc_d  = nxt;
              res_d = ST_OK;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_LT, OP_GT, OP_EQ, OP_DIV: begin
            if (empty) begin
              res_d = ST_ERROR;
            end else if (sp_q == SP_W'(1)) begin
              sp_d = '0;
            end else if ((op_q == OP_DIV) && (tos_q == '0)) begin
              sp_d  = sp_q - SP_W'(1);
              tos_d = ds_rdata;
            end else begin
              alu_req = '{start: 1'b1, op: to_alu(op_q), a: ds_rdata, b: tos_q};
              state_d = SQ_ALU;
            end
          end
          OP_NEG: begin
            if (!empty) begin
              alu_req = '{start: 1'b1, op: ALU_NEG, a: tos_q, b: tos_q};
              state_d = SQ_ALU;
            end
          end
          OP_STORE, OP_VSET, OP_ACT, OP_JZ, OP_JNZ, OP_POP: begin
            if (!(((op_q == OP_STORE) && !loc_ok) || ((op_q == OP_ACT) && !io_ok)) &&
                !empty) begin
              sp_d  = sp_q - SP_W'(1);
              tos_d = ds_rdata;
              pc_d  = nxt;
              res_d = ST_OK;
              case (op_q)
                OP_STORE: locals_d[opd_q[LI_W-1:0]] = tos_q;
                OP_VSET:  vibe_d = tos_q;
                OP_ACT: begin
                  actw_d = 1'b1;
                  acti_d = opd_q[2:0];
                  actv_d = tos_q;
                end
                OP_JZ:    if (tos_q == '0) pc_d = opd_q;
                OP_JNZ:   if (tos_q != '0) pc_d = opd_q;
                default:  ;
              endcase
            end
          end
          OP_SWAP: begin
            if (!empty && (sp_q != SP_W'(1))) begin
              ds_we    = 1'b1;
              ds_waddr = ds_raddr;
              ds_wdata = tos_q;
              nos_d    = ds_rdata;
              state_d  = SQ_SWAP;
            end
          end
          OP_JMP: begin
            pc_d  = opd_q;
            res_d = ST_OK;
          end
          OP_CALL: begin
            if (rp_q != RP_W'(RETURN_DEPTH)) begin
              rs_we = 1'b1;
              rp_d  = rp_q + RP_W'(1);
              pc_d  = opd_q;
              res_d = ST_OK;
            end
          end
          OP_RET: begin
            if (rp_q != '0) begin
              rp_d  = rp_q - RP_W'(1);
              pc_d  = rs_rdata;
              res_d = ST_OK;
            end
          end
          OP_HALT: begin
            halted_d = 1'b1;
            res_d    = ST_HALTED;
          end
          default: res_d = ST_ERROR;
        endcase
      end
      SQ_ALU: begin
        if (alu_rsp.done) begin
          ds_we    = 1'b1;
          ds_wdata = alu_rsp.res;
          tos_d    = alu_rsp.res;
          if (op_q == OP_NEG) begin
            ds_waddr = SA_W'(sp_q - SP_W'(1));
          end else begin
            ds_waddr = ds_raddr;
            sp_d     = sp_q - SP_W'(1);
          end
          pc_d    = nxt;
          res_d   = ST_OK;
          state_d = SQ_DONE;
        end
      end
      SQ_SWAP: begin
        ds_we    = 1'b1;
        ds_waddr = SA_W'(sp_q - SP_W'(1));
        ds_wdata = nos_q;
        tos_d    = nos_q;
        pc_d     = nxt;
        res_d    = ST_OK;
        state_d  = SQ_DONE;
      end
      SQ_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = SQ_IDLE;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      sp_q        <= '0;
      rp_q        <= '0;
      pc_q        <= '0;
      vibe_q      <= '0;
      ticks_q     <= '0;
      halted_q    <= 1'b0;
      locals_q    <= '{default: '0};
      plen_q      <= PLEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sp_q     <= sp_d;
      rp_q     <= rp_d;
      pc_q     <= pc_d;
      vibe_q   <= vibe_d;
      ticks_q  <= ticks_d;
      halted_q <= halted_d;
      locals_q <= locals_d;
      if (cfg_valid_i) begin
        plen_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload, stack caches and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opc_e'(opcode_i);
      opd_q  <= operand_i | imm_dummy;
      imm_q  <= immediate_i;
      sens_q <= sensor_reading_i;
    end
    tos_q  <= tos_d;
    nos_q  <= nos_d;
    res_q  <= res_d;
    actw_q <= actw_d;
    acti_q <= acti_d;
    actv_q <= actv_d;
    if (out_load) begin
      status_o         <= res_q;
      next_pc_o        <= pc_q;
      top_value_o      <= (sp_q != '0) ? tos_q : 64'd0;
      stack_depth_o    <= 9'(sp_q);
      call_depth_o     <= 7'(rp_q);
      actuator_write_o <= actw_q;
      actuator_index_o <= acti_q;
      actuator_value_o <= actv_q;
      tick_count_o     <= ticks_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `SBE_ASSERT_NOW(a_sp_bound, 1'b1, sp_q <= SP_W'(STACK_DEPTH), "data stack pointer past depth")
  `SBE_ASSERT_NOW(a_rp_bound, 1'b1, rp_q <= RP_W'(RETURN_DEPTH), "return pointer past depth")
  `SBE_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q, "halt flag cleared without reset")
  `SBE_ASSERT_NEXT(a_tick_hold, state_q != SQ_IDLE, ticks_q == $past(ticks_q),
                   "tick advanced outside item acceptance")

endmodule
